// File: rtl/core/csra_pkg.sv
// Shared types, codes and defaults for the contiguous slot run allocator.
`timescale 1ns / 1ps

package csra_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int POOLS_DEF = 8;

    localparam int COUNT_W  = 6;
    localparam int POOL_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE   = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] count;
        logic [POOL_W-1:0]  pool_index;
        logic [SLOT_W-1:0]  slot_index;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   granted_pool;
        logic [SLOT_W-1:0]   granted_slot;
        logic                opened_pool;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FREE_CHK,
        S_RESULT
    } t_state;

endpackage

// File: rtl/core/csra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module csra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/csra_fit.sv
// First-fit search for a run of free slots within one pool's free map.
`timescale 1ns / 1ps

module csra_fit import csra_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic [SLOTS-1:0]         i_free,
    input  logic [COUNT_W-1:0]       i_count,
    output logic                     o_found,
    output logic [$clog2(SLOTS)-1:0] o_slot,
    output logic [SLOTS-1:0]         o_run,
    output logic [SLOTS-1:0]         o_mask
);

    localparam int SW = $clog2(SLOTS);

    logic [SLOTS-1:0] fit;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_run[i] = (i < int'(i_count));
        end
    end

    // A start position fits when every slot of the run is free and the run
    // stays inside the pool.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            fit[s] = (((i_free >> s) & o_run) == o_run) && (s + int'(i_count) <= SLOTS);
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (fit[s]) begin
                o_found = 1'b1;
                o_slot  = SW'(s);
            end
        end
    end

    assign o_mask = o_run << o_slot;

endmodule

// File: rtl/core/contiguous_slot_run_allocator.sv
// Top level of the contiguous slot run allocator: sequencer, pool counter and map RAM.
`timescale 1ns / 1ps

// The allocator keeps one free map per pool in a single RAM, one word per pool, and handles
// one request at a time. An allocate reads the active pools one per cycle, newest first,
// and takes the lowest free run of the requested length; if none fits, the next unused
// pool is opened with its first slots taken. The pools are read one at a time, as the map
// RAM has a single read port, so an allocate reads 1 up to the active pool count of them.
// A free passes through decode, a free check and the result state; a request with a bad
// count or bad handle goes from decode to the result state. Valid bits per pool stand in for
// the reset state of the map, so there is no clearing pass after reset. The next request is
// taken once the result has moved to the output register, which holds it while the far side stalls.
module contiguous_slot_run_allocator import csra_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int POOLS = POOLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int CW = $clog2(POOLS + 1);
    localparam int SW = $clog2(SLOTS);

    t_state          r_state, n_state;
    t_in_beat        r_req, n_req;
    logic [CW-1:0]   r_act_cnt, n_act_cnt;
    logic [POOLS-1:0] r_valid, n_valid;
    logic [PW-1:0]   r_rd_pool, n_rd_pool;
    t_out_beat       r_res, n_res;
    t_out_beat       r_out;
    logic            r_out_vld;

    logic             ram_we, ram_re;
    logic [PW-1:0]    ram_waddr, ram_raddr;
    logic [SLOTS-1:0] ram_wdata, ram_rdata, map_word;

    logic             fit_found;
    logic [SW-1:0]    fit_slot;
    logic [SLOTS-1:0] fit_run, fit_mask, free_mask;

    logic bad_count, bad_handle, all_open, out_free;

    csra_ram #(
        .WIDTH (SLOTS),
        .DEPTH (POOLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A pool never written since reset still has every slot free.
    assign map_word = r_valid[r_rd_pool] ? ram_rdata : '1;

    csra_fit #(
        .SLOTS (SLOTS)
    ) u_fit (
        .i_free  (map_word),
        .i_count (r_req.count),
        .o_found (fit_found),
        .o_slot  (fit_slot),
        .o_run   (fit_run),
        .o_mask  (fit_mask)
    );

    assign free_mask  = fit_run << r_req.slot_index;
    assign bad_count  = (r_req.count == '0) || (32'(r_req.count) > 32'(SLOTS));
    assign bad_handle = (32'(r_req.pool_index) >= 32'(r_act_cnt))
                     || (32'(r_req.slot_index) + 32'(r_req.count) > 32'(SLOTS));
    assign all_open   = (32'(r_act_cnt) >= 32'(POOLS));
    assign out_free   = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (bad_count) begin
                    n_state = S_RESULT;
                end else if (r_req.kind == KIND_FREE) begin
                    n_state = bad_handle ? S_RESULT : S_FREE_CHK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (fit_found || r_rd_pool == '0) begin
                    n_state = S_RESULT;
                end
            end
            S_FREE_CHK: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req     = r_req;
        n_act_cnt = r_act_cnt;
        n_valid   = r_valid;
        n_rd_pool = r_rd_pool;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_rd_pool;
        ram_wdata = map_word;
        ram_re    = 1'b0;
        ram_raddr = r_rd_pool;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                end
            end
            S_DECODE: begin
                n_res = '0;
                if (bad_count) begin
                    n_res.status = ST_BAD_COUNT;
                end else if (r_req.kind == KIND_FREE) begin
                    if (bad_handle) begin
                        n_res.status = ST_BAD_HANDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = PW'(r_req.pool_index);
                        n_rd_pool = PW'(r_req.pool_index);
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = PW'(r_act_cnt - CW'(1));
                    n_rd_pool = PW'(r_act_cnt - CW'(1));
                end
            end
            S_SCAN: begin
                if (fit_found) begin
                    ram_we             = 1'b1;
                    ram_waddr          = r_rd_pool;
                    ram_wdata          = map_word & ~fit_mask;
                    n_valid[r_rd_pool] = 1'b1;
                    n_res.status       = ST_OK;
                    n_res.granted_pool = POOL_W'(r_rd_pool);
                    n_res.granted_slot = SLOT_W'(fit_slot);
                end else if (r_rd_pool == '0) begin
                    if (all_open) begin
                        n_res.status = ST_NO_SPACE;
                    end else begin
                        // Open the next pool with the run taken from slot zero.
                        ram_we                   = 1'b1;
                        ram_waddr                = PW'(r_act_cnt);
                        ram_wdata                = ~fit_run;
                        n_valid[PW'(r_act_cnt)]  = 1'b1;
                        n_act_cnt                = r_act_cnt + CW'(1);
                        n_res.status             = ST_OK;
                        n_res.granted_pool       = POOL_W'(r_act_cnt);
                        n_res.opened_pool        = 1'b1;
                    end
                end else begin
                    // Read the next older pool while this one is checked.
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_pool - PW'(1);
                    n_rd_pool = r_rd_pool - PW'(1);
                end
            end
            S_FREE_CHK: begin
                if ((map_word & free_mask) != '0) begin
                    n_res.status = ST_ALREADY_FREE;
                end else begin
                    ram_we             = 1'b1;
                    ram_waddr          = r_rd_pool;
                    ram_wdata          = map_word | free_mask;
                    n_valid[r_rd_pool] = 1'b1;
                    n_res.status       = ST_OK;
                end
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_act_cnt <= CW'(1);
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_act_cnt <= n_act_cnt;
            r_valid   <= n_valid;
            if (r_state == S_RESULT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd_pool <= n_rd_pool;
        r_res     <= n_res;
        if (r_state == S_RESULT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: tb/sv/contiguous_slot_run_allocator_tb.sv
// Self-checking testbench for the contiguous slot run allocator.
`timescale 1ns / 1ps

module contiguous_slot_run_allocator_tb;
    import csra_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int POOLS        = POOLS_DEF;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1625;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3 + POOLS + 8;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_directed_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    // Predicted allocator state: one free bit per slot, and the number of pools in use.
    logic [SLOTS-1:0] slot_free_map [POOLS];
    int               open_pools;

    t_out_beat     pending_results [$];
    t_directed_row directed_rows [N_DIRECTED];

    bit          send_jitter  = 1'b1;
    bit          stall_jitter = 1'b1;
    int unsigned cycle_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_beats = 0, n_grants = 0, n_opened = 0, n_frees = 0;
    int unsigned n_bad_count = 0, n_no_space = 0, n_already_free = 0, n_bad_handle = 0;

    contiguous_slot_run_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic t_out_beat predict_outcome(t_in_beat b);
        t_out_beat        r;
        logic [SLOTS-1:0] run;
        logic [SLOTS-1:0] m;
        int               p;
        int               s;
        bit               placed;
        r = '0;
        placed = 1'b0;
        if (b.count == 0 || int'(b.count) > SLOTS) begin
            r.status = ST_BAD_COUNT;
            return r;
        end
        run = {SLOTS{1'b1}} >> (SLOTS - int'(b.count));
        if (b.kind == KIND_ALLOC) begin
            // Newest pool first; within a pool the lowest free run wins.
            for (p = open_pools - 1; p >= 0 && !placed; p--) begin
                for (s = 0; s + int'(b.count) <= SLOTS && !placed; s++) begin
                    m = run << s;
                    if ((slot_free_map[p] & m) == m) begin
                        slot_free_map[p] &= ~m;
                        r.status       = ST_OK;
                        r.granted_pool = POOL_W'(p);
                        r.granted_slot = SLOT_W'(s);
                        placed = 1'b1;
                    end
                end
            end
            if (!placed) begin
                if (open_pools >= POOLS) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    slot_free_map[open_pools] = ~run;
                    r.status       = ST_OK;
                    r.granted_pool = POOL_W'(open_pools);
                    r.opened_pool  = 1'b1;
                    open_pools++;
                end
            end
        end else if (int'(b.pool_index) >= open_pools ||
                     int'(b.slot_index) + int'(b.count) > SLOTS) begin
            r.status = ST_BAD_HANDLE;
        end else begin
            m = run << b.slot_index;
            if ((slot_free_map[b.pool_index] & m) != '0) begin
                r.status = ST_ALREADY_FREE;
            end else begin
                slot_free_map[b.pool_index] |= m;
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    function automatic t_directed_row dir_row(logic kind, int count, int pool, int slot,
                                              bit typed, logic [STATUS_W-1:0] status,
                                              int gpool, int gslot, logic opened);
        t_directed_row row;
        row.beat.kind       = kind;
        row.beat.count      = COUNT_W'(count);
        row.beat.pool_index = POOL_W'(pool);
        row.beat.slot_index = SLOT_W'(slot);
        row.typed              = typed;
        row.want.status        = status;
        row.want.granted_pool  = POOL_W'(gpool);
        row.want.granted_slot  = SLOT_W'(gslot);
        row.want.opened_pool   = opened;
        return row;
    endfunction

    // Most random beats are allocates and frees of runs that really are in use, so the
    // maps keep churning; the rest are bad counts, likely double frees and plain noise.
    function automatic t_in_beat next_random_beat();
        t_in_beat b;
        int       sel;
        int       p0;
        int       p;
        int       s0;
        int       s;
        int       k;
        int       tries;
        int       maxlen;
        bit       got;
        b = '0;
        b.pool_index = POOL_W'($urandom_range(POOLS - 1));
        b.slot_index = SLOT_W'($urandom_range(SLOTS - 1));
        sel = $urandom_range(99);
        if (sel < 8) begin
            b = t_in_beat'($urandom_range(2 ** $bits(t_in_beat) - 1));
            return b;
        end
        if (sel < 13) begin
            b.kind  = logic'($urandom_range(1));
            b.count = $urandom_range(1) ? '0 : COUNT_W'($urandom_range(SLOTS + 1, 63));
            return b;
        end
        if (sel < 20) begin
            b.kind  = KIND_FREE;
            b.count = COUNT_W'($urandom_range(1, 4));
            return b;
        end
        got = 1'b0;
        p = 0;
        s = 0;
        if (sel >= 58) begin
            p0 = $urandom_range(open_pools - 1);
            for (tries = 0; tries < open_pools && !got; tries++) begin
                p = (p0 + tries) % open_pools;
                if (slot_free_map[p] != {SLOTS{1'b1}}) begin
                    s0 = $urandom_range(SLOTS - 1);
                    for (k = 0; k < SLOTS; k++) begin
                        s = (s0 + k) % SLOTS;
                        if (!slot_free_map[p][s]) begin
                            break;
                        end
                    end
                    got = 1'b1;
                end
            end
        end
        if (got) begin
            maxlen = 0;
            while (s + maxlen < SLOTS && !slot_free_map[p][s + maxlen]) begin
                maxlen++;
            end
            b.kind       = KIND_FREE;
            b.pool_index = POOL_W'(p);
            b.slot_index = SLOT_W'(s);
            b.count      = COUNT_W'(($urandom_range(3) == 0) ? maxlen
                                                           : $urandom_range(1, maxlen));
        end else begin
            b.kind  = KIND_ALLOC;
            b.count = COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(1, SLOTS)
                                                        : $urandom_range(1, 4));
        end
        return b;
    endfunction

    // Drives one beat, holds it until it is taken, then records what must come back.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat typed_want);
        t_out_beat predicted;
        while (send_jitter && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predicted = predict_outcome(b);
        if (typed) begin
            predicted = typed_want;
        end
        pending_results.push_back(predicted);
        n_beats++;
        case (predicted.status)
            ST_OK: begin
                if (b.kind == KIND_ALLOC) begin
                    n_grants++;
                    n_opened += predicted.opened_pool;
                end else begin
                    n_frees++;
                end
            end
            ST_BAD_COUNT:    n_bad_count++;
            ST_NO_SPACE:     n_no_space++;
            ST_ALREADY_FREE: n_already_free++;
            default:         n_bad_handle++;
        endcase
    endtask

    // Waits on the clock before it checks the queue, so valid is never lowered and raised in one step.
    task automatic drain_results();
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: %p", o_out_data);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        mismatch_count++;
                    end
                    if (o_out_data.granted_pool !== want.granted_pool) begin
                        $error("granted_pool: expected %0d, got %0d",
                               want.granted_pool, o_out_data.granted_pool);
                        mismatch_count++;
                    end
                    if (o_out_data.granted_slot !== want.granted_slot) begin
                        $error("granted_slot: expected %0d, got %0d",
                               want.granted_slot, o_out_data.granted_slot);
                        mismatch_count++;
                    end
                    if (o_out_data.opened_pool !== want.opened_pool) begin
                        $error("opened_pool: expected %0d, got %0d",
                               want.opened_pool, o_out_data.opened_pool);
                        mismatch_count++;
                    end
                end
            end
            i_out_stall <= stall_jitter && ($urandom_range(99) < 28);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("contiguous_slot_run_allocator_tb failed");
        $finish;
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < POOLS; i++) begin
            slot_free_map[i] = {SLOTS{1'b1}};
        end
        open_pools = 1;

        directed_rows = '{
            // Zero and oversized counts, on both kinds; pool and slot are ignored on allocate.
            dir_row(KIND_ALLOC, 0,  0, 0,  1, ST_BAD_COUNT, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 63, 7, 15, 1, ST_BAD_COUNT, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 17, 0, 0,  1, ST_BAD_COUNT, 0, 0, 1'b0),
            dir_row(KIND_FREE,  0,  0, 0,  1, ST_BAD_COUNT, 0, 0, 1'b0),
            dir_row(KIND_FREE,  32, 0, 0,  1, ST_BAD_COUNT, 0, 0, 1'b0),
            // Free in a pool not yet in use, and a run that runs past the pool end.
            dir_row(KIND_FREE,  1,  7, 15, 1, ST_BAD_HANDLE, 0, 0, 1'b0),
            dir_row(KIND_FREE,  2,  0, 15, 1, ST_BAD_HANDLE, 0, 0, 1'b0),
            dir_row(KIND_FREE,  1,  0, 0,  1, ST_ALREADY_FREE, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 3, 9,  1, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 1,  0, 0,  1, ST_OK, 1, 0, 1'b1),
            dir_row(KIND_ALLOC, 15, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_FREE,  16, 0, 0,  1, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 3,  0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 2,  0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_FREE,  1,  0, 4,  0, ST_OK, 0, 0, 1'b0),
            // Double free where only part of the run is already free: nothing may change.
            dir_row(KIND_FREE,  2,  0, 3,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 1,  0, 0,  0, ST_OK, 0, 0, 1'b0),
            // Fill every remaining pool, then ask once more with nothing left.
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 0, 0,  0, ST_OK, 0, 0, 1'b0),
            dir_row(KIND_ALLOC, 16, 7, 15, 1, ST_NO_SPACE, 0, 0, 1'b0),
            dir_row(KIND_FREE,  16, 7, 0,  1, ST_OK, 0, 0, 1'b0)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end
        i_in_valid <= 1'b0;
        drain_results();

        for (i = 0; i < N_RANDOM; i++) begin
            send_jitter  = !(i >= 700 && i < 1000);
            stall_jitter = send_jitter;
            if (i == 1200) begin
                i_in_valid <= 1'b0;
                drain_results();
            end
            send_beat(next_random_beat(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats: %0d runs granted, %0d of them opening a pool, %0d runs freed.",
                 n_beats, n_grants, n_opened, n_frees);
        $display("Refused: %0d bad count, %0d no space, %0d already free, %0d bad handle.",
                 n_bad_count, n_no_space, n_already_free, n_bad_handle);
        if (mismatch_count == 0) begin
            $display("contiguous_slot_run_allocator_tb passed");
        end else begin
            $display("contiguous_slot_run_allocator_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/csra_pkg.sv
rtl/core/csra_ram.sv
rtl/core/csra_fit.sv
rtl/core/contiguous_slot_run_allocator.sv
tb/sv/contiguous_slot_run_allocator_tb.sv
